/* sv/grid_factor_split_defines.svh */
// ---------------------------------------------------------------------------
// grid_factor_split assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef GRID_FACTOR_SPLIT_DEFINES_SVH
`define GRID_FACTOR_SPLIT_DEFINES_SVH

// same-cycle implication
`define GFS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("grid_factor_split: same-cycle check failed");

// next-cycle implication
`define GFS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("grid_factor_split: next-cycle check failed");

`endif

/* sv/gfs_pkg.sv */
// ---------------------------------------------------------------------------
// gfs_pkg
// Widths, microcode format and control store of the grid factor splitter.
// ---------------------------------------------------------------------------
package gfs_pkg;

	localparam int unsigned GFS_COUNT_WIDTH = 24;
	localparam int unsigned FIRST_W         = 13;
	localparam int unsigned SECOND_W        = 24;

	localparam int unsigned GFS_DIV3 = 3;
	localparam int unsigned GFS_DIV5 = 5;

	typedef logic [3:0] step_t;

	localparam step_t ST_IDLE  = 4'd0;
	localparam step_t ST_SQRT  = 4'd1;
	localparam step_t ST_SQCHK = 4'd2;
	localparam step_t ST_HALVE = 4'd3;
	localparam step_t ST_MUL3  = 4'd4;
	localparam step_t ST_CHK3  = 4'd5;
	localparam step_t ST_MUL5  = 4'd6;
	localparam step_t ST_CHK5  = 4'd7;
	localparam step_t ST_PREM  = 4'd8;
	localparam step_t ST_PL5   = 4'd9;
	localparam step_t ST_PL3   = 4'd10;
	localparam step_t ST_PL2   = 4'd11;
	localparam step_t ST_DONE  = 4'd12;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_SQRT,
		OP_SQCHK,
		OP_HALVE,
		OP_DMUL,
		OP_DCHK,
		OP_PREM,
		OP_PLACE,
		OP_DONE
	} op_t;

	typedef enum logic [2:0] {
		C_NEXT,
		C_ALWAYS,
		C_BITS,
		C_SQUARE,
		C_EVEN,
		C_DIV,
		C_CNT
	} cond_t;

	typedef enum logic [1:0] {
		FAC_2,
		FAC_3,
		FAC_5
	} fac_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
		fac_t  fac;
	} uword_t;

	// control store: jump to target when cond holds, else fall through
	function automatic uword_t gfs_ucode(input step_t step);
		uword_t w;
		case (step)
			ST_IDLE:  w = '{OP_NOP,   C_NEXT,   ST_IDLE,  FAC_2};
			ST_SQRT:  w = '{OP_SQRT,  C_BITS,   ST_SQRT,  FAC_2};
			ST_SQCHK: w = '{OP_SQCHK, C_SQUARE, ST_DONE,  FAC_2};
			ST_HALVE: w = '{OP_HALVE, C_EVEN,   ST_HALVE, FAC_2};
			ST_MUL3:  w = '{OP_DMUL,  C_NEXT,   ST_IDLE,  FAC_3};
			ST_CHK3:  w = '{OP_DCHK,  C_DIV,    ST_MUL3,  FAC_3};
			ST_MUL5:  w = '{OP_DMUL,  C_NEXT,   ST_IDLE,  FAC_5};
			ST_CHK5:  w = '{OP_DCHK,  C_DIV,    ST_MUL5,  FAC_5};
			ST_PREM:  w = '{OP_PREM,  C_NEXT,   ST_IDLE,  FAC_2};
			ST_PL5:   w = '{OP_PLACE, C_CNT,    ST_PL5,   FAC_5};
			ST_PL3:   w = '{OP_PLACE, C_CNT,    ST_PL3,   FAC_3};
			ST_PL2:   w = '{OP_PLACE, C_CNT,    ST_PL2,   FAC_2};
			ST_DONE:  w = '{OP_DONE,  C_ALWAYS, ST_IDLE,  FAC_2};
			default:  w = '{OP_NOP,   C_ALWAYS, ST_IDLE,  FAC_2};
		endcase
		return w;
	endfunction

endpackage

/* sv/gfs_cdiv.sv */
// ---------------------------------------------------------------------------
// gfs_cdiv
// Trial division by 3 or 5: registered reciprocal multiply, then one
// remainder correction.
// ---------------------------------------------------------------------------
module gfs_cdiv import gfs_pkg::*; #(
	parameter int unsigned COUNT_WIDTH = GFS_COUNT_WIDTH
) (
	input  logic                   clk,
	input  logic [COUNT_WIDTH-1:0] n,
	input  fac_t                   fac,
	output logic [COUNT_WIDTH-1:0] q,
	output logic                   divisible
);

	localparam int unsigned MW = COUNT_WIDTH - 1;
	localparam int unsigned PW = COUNT_WIDTH + MW;
	localparam longint unsigned RECIP3 = (64'd1 << COUNT_WIDTH) / GFS_DIV3;
	localparam longint unsigned RECIP5 = (64'd1 << COUNT_WIDTH) / GFS_DIV5;

	logic [MW-1:0]          recip;
	logic [PW-1:0]          prod_s1;
	logic [COUNT_WIDTH-1:0] q_est;
	logic [COUNT_WIDTH-1:0] q_mul;
	logic [COUNT_WIDTH-1:0] rem;
	logic [COUNT_WIDTH-1:0] dval;
	logic                   rem_hi;

	always_comb begin
		case (fac)
			FAC_5:   begin recip = MW'(RECIP5); dval = COUNT_WIDTH'(GFS_DIV5); end
			default: begin recip = MW'(RECIP3); dval = COUNT_WIDTH'(GFS_DIV3); end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_s1 <= PW'(n) * PW'(recip);
	end

	// estimate is floor(n/d) or one below it
	assign q_est = COUNT_WIDTH'(prod_s1[PW-1:COUNT_WIDTH]);

	always_comb begin
		case (fac)
			FAC_5:   q_mul = (q_est << 2) + q_est;
			default: q_mul = (q_est << 1) + q_est;
		endcase
	end

	assign rem       = n - q_mul;
	assign rem_hi    = (rem == dval);
	assign divisible = (rem == '0) || rem_hi;
	assign q         = q_est + COUNT_WIDTH'(rem_hi);

endmodule

/* sv/grid_factor_split.sv */
// ---------------------------------------------------------------------------
// grid_factor_split
// Splits a count into two grid dimensions whose product is the count.
// ---------------------------------------------------------------------------
//
//  channel   | handshake              | payload
//  ----------+------------------------+---------------------------------
//  command   | start (in), busy (out) | count [COUNT_WIDTH-1:0]
//  result    | done (out, one cycle)  | dim_first [12:0], dim_second [23:0]
//
//  A transaction is accepted on a rising edge with start high and busy low.
//  The sequencer issues one control word per cycle: one root bit per step,
//  two steps per trial division by 3 or 5. A perfect square then goes
//  straight to the done step; any other count is halved, divided by 3 and
//  by 5, its leftover factor is taken, and the factors 5, 3, 2 are placed.
//  busy drops in the cycle done is shown, so the next command can go then.
//  arst_n clears the step counter and the strobe; no clearing pass.
//  The receiver cannot stall; done is a single-cycle strobe.
//
module grid_factor_split import gfs_pkg::*; #(
	parameter int unsigned COUNT_WIDTH = GFS_COUNT_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [COUNT_WIDTH-1:0] count,
	output logic                   busy,
	output logic                   done,
	output logic [FIRST_W-1:0]     dim_first,
	output logic [SECOND_W-1:0]    dim_second
);

	localparam int unsigned CW    = COUNT_WIDTH;
	localparam int unsigned RW    = (CW + 1) / 2;     // root width
	localparam int unsigned BI_W  = $clog2(RW);       // root bit index
	localparam int unsigned CNT_W = $clog2(CW);       // factor multiplicity
	localparam int unsigned SQ_W  = 2 * RW;

	// sequencer
	step_t  pc_q;
	uword_t uw;
	logic   accept;
	logic   take;

	// datapath
	logic [CW-1:0]    n_q;
	logic [RW-1:0]    rt_q;
	logic [BI_W-1:0]  bi_q;
	logic [RW-1:0]    a_q;
	logic [CW-1:0]    b_q;
	logic [CNT_W-1:0] c2_q, c3_q, c5_q;
	logic [FIRST_W-1:0]  dim_first_q;
	logic [SECOND_W-1:0] dim_second_q;
	logic                done_q;

	logic [RW-1:0]    cand;
	logic [RW-1:0]    sq_op;
	logic [SQ_W-1:0]  sq;
	logic [SQ_W-1:0]  n_ext;
	logic             sq_le;
	logic             is_sq;
	logic             n_gt1;
	logic [CNT_W-1:0] cnt_sel;
	logic [RW+2:0]    a_x, a_f;
	logic [CW-1:0]    b_f;
	logic             a_fits;
	logic [CW-1:0]    div_q;
	logic             div_ok;

	assign uw     = gfs_ucode(pc_q);
	assign busy   = (pc_q != ST_IDLE);
	assign accept = start && !busy;

	// root trial: candidate squared against n; on the check step, root squared
	assign cand  = rt_q | (RW'(1) << bi_q);
	assign sq_op = (uw.op == OP_SQCHK) ? rt_q : cand;
	assign sq    = SQ_W'(sq_op) * SQ_W'(sq_op);
	assign n_ext = SQ_W'(n_q);
	assign sq_le = (sq <= n_ext);
	assign is_sq = (sq == n_ext);
	assign n_gt1 = (n_q > CW'(1));

	always_comb begin
		case (uw.fac)
			FAC_5:   cnt_sel = c5_q;
			FAC_3:   cnt_sel = c3_q;
			default: cnt_sel = c2_q;
		endcase
	end

	// constant-factor products for placement; b*f never exceeds the count
	assign a_x = (RW + 3)'(a_q);
	always_comb begin
		case (uw.fac)
			FAC_5:   begin a_f = (a_x << 2) + a_x; b_f = (b_q << 2) + b_q; end
			FAC_3:   begin a_f = (a_x << 1) + a_x; b_f = (b_q << 1) + b_q; end
			default: begin a_f = a_x << 1;         b_f = b_q << 1;         end
		endcase
	end
	assign a_fits = (a_f <= (RW + 3)'(rt_q));

	gfs_cdiv #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_cdiv (
		.clk       (clk),
		.n         (n_q),
		.fac       (uw.fac),
		.q         (div_q),
		.divisible (div_ok)
	);

	// jump condition of the current control word
	always_comb begin
		case (uw.cond)
			C_ALWAYS: take = 1'b1;
			C_BITS:   take = (bi_q != '0);
			C_SQUARE: take = is_sq;
			C_EVEN:   take = n_gt1 && !n_q[0];
			C_DIV:    take = n_gt1 && div_ok;
			C_CNT:    take = (cnt_sel != '0);
			default:  take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= ST_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= busy && (uw.op == OP_DONE);
			if (!busy) begin
				pc_q <= accept ? ST_SQRT : ST_IDLE;
			end else if (take) begin
				pc_q <= uw.target;
			end else begin
				pc_q <= pc_q + step_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			n_q  <= count;
			rt_q <= '0;
			bi_q <= BI_W'(RW - 1);
			a_q  <= RW'(1);
			b_q  <= CW'(1);
			c2_q <= '0;
			c3_q <= '0;
			c5_q <= '0;
		end else if (busy) begin
			case (uw.op)
				OP_SQRT: begin
					if (sq_le) rt_q <= cand;
					if (bi_q != '0) bi_q <= bi_q - BI_W'(1);
				end
				OP_SQCHK: begin
					if (is_sq) begin
						a_q <= rt_q;
						b_q <= CW'(rt_q);
					end
				end
				OP_HALVE: begin
					if (n_gt1 && !n_q[0]) begin
						n_q  <= n_q >> 1;
						c2_q <= c2_q + CNT_W'(1);
					end
				end
				OP_DCHK: begin
					if (n_gt1 && div_ok) begin
						n_q <= div_q;
						if (uw.fac == FAC_5) c5_q <= c5_q + CNT_W'(1);
						else                 c3_q <= c3_q + CNT_W'(1);
					end
				end
				OP_PREM: begin
					// leftover factor: both dimensions are still 1 here
					if (n_gt1) begin
						if (n_q <= CW'(rt_q)) a_q <= RW'(n_q);
						else                  b_q <= n_q;
					end
				end
				OP_PLACE: begin
					if (cnt_sel != '0) begin
						if (a_fits) a_q <= RW'(a_f);
						else        b_q <= b_f;
						case (uw.fac)
							FAC_5:   c5_q <= c5_q - CNT_W'(1);
							FAC_3:   c3_q <= c3_q - CNT_W'(1);
							default: c2_q <= c2_q - CNT_W'(1);
						endcase
					end
				end
				OP_DONE: begin
					dim_first_q  <= FIRST_W'(a_q);
					dim_second_q <= SECOND_W'(b_q);
				end
				default: ;
			endcase
		end
	end

	assign done       = done_q;
	assign dim_first  = dim_first_q;
	assign dim_second = dim_second_q;

endmodule

/* sv/gfs_checker.sv */
// ---------------------------------------------------------------------------
// gfs_checker
// Port-level checks of the grid factor splitter, bound to the top level.
// ---------------------------------------------------------------------------
`include "grid_factor_split_defines.svh"

module gfs_checker import gfs_pkg::*; #(
	parameter int unsigned COUNT_WIDTH = GFS_COUNT_WIDTH
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   start,
	input logic [COUNT_WIDTH-1:0] count,
	input logic                   busy,
	input logic                   done,
	input logic [FIRST_W-1:0]     dim_first,
	input logic [SECOND_W-1:0]    dim_second
);

	localparam int unsigned PW = FIRST_W + SECOND_W;
	// dimensions are shown untruncated only when they fit the result ports
	localparam bit FULL = (COUNT_WIDTH <= SECOND_W) && ((COUNT_WIDTH + 1) / 2 <= FIRST_W);

	logic [COUNT_WIDTH-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (start && !busy) cnt_q <= count;
	end

	`GFS_ASSERT_NXT(a_accept_busy, start && !busy, busy)
	`GFS_ASSERT_NXT(a_done_pulse, done, !done)
	`GFS_ASSERT_IMP(a_done_after_busy, done, $past(busy))
	`GFS_ASSERT_IMP(a_product, done && FULL, PW'(dim_first) * PW'(dim_second) == PW'(cnt_q))
	`GFS_ASSERT_IMP(a_first_root, done && FULL, PW'(dim_first) * PW'(dim_first) <= PW'(cnt_q))

endmodule

bind grid_factor_split gfs_checker #(
	.COUNT_WIDTH(COUNT_WIDTH)
) u_gfs_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.count      (count),
	.busy       (busy),
	.done       (done),
	.dim_first  (dim_first),
	.dim_second (dim_second)
);
